// ===== hdl/qlsf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the quadratic fit core.
package qlsf_pkg;

  localparam int unsigned SUM_W  = 40;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned THR_W  = 25;
  localparam int unsigned IN_W   = 24;
  localparam int unsigned OUT_W  = 208;
  localparam int unsigned USER_W = 2;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [1:0] COL_RHS = 2'd3;
  localparam logic [1:0] ROW_END = 2'd3;

  typedef struct packed {
    logic sat;
    logic [63:0] val;
  } fx_res_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       pivot;
    logic       div_start;
    logic       div_write;
    logic       row_start;
    logic       mul_start;
    logic       sub_write;
    logic       emit;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic singular;
    logic div_done;
    logic mul_done;
    logic out_busy;
  } sts_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic fx_res_t fx_pack(input logic hi_nz, input logic [63:0] m,
                                      input logic neg);
    fx_res_t r;
    logic [63:0] lim;
    logic [63:0] mm;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    mm = m;
    r.sat = 1'b0;
    if (hi_nz || (m > lim)) begin
      r.sat = 1'b1;
      mm = lim;
    end
    r.val = neg ? (64'd0 - mm) : mm;
    return r;
  endfunction

endpackage

// ===== hdl/qlsf_divider.sv =====
// Restoring fixed-point divider, one quotient bit per cycle, rounded half away from zero.
module qlsf_divider #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] q_o,
  output logic        sat_o
);

  typedef enum logic [1:0] {D_IDLE, D_STEP, D_ROUND, D_PACK} dstate_e;

  dstate_e      state_q;
  logic [6:0]   cnt_q;
  logic [127:0] n_q;
  logic [127:0] q_q;
  logic [63:0]  r_q;
  logic [63:0]  mb_q;
  logic         neg_q;
  logic         done_q;
  logic [63:0]  res_q;
  logic         sat_q;

  logic [64:0]  r_sh;
  logic         ge;
  qlsf_pkg::fx_res_t pk;

  assign r_sh = {r_q, n_q[127]};
  assign ge   = r_sh >= {1'b0, mb_q};
  assign pk   = qlsf_pkg::fx_pack(|q_q[127:64], q_q[63:0], neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= a_i[63] ^ b_i[63];
            n_q     <= {64'd0, qlsf_pkg::mag(a_i)} << FRAC_BITS;
            mb_q    <= qlsf_pkg::mag(b_i);
            r_q     <= '0;
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= D_STEP;
          end
        end
        D_STEP: begin
          r_q   <= ge ? 64'(r_sh - {1'b0, mb_q}) : r_sh[63:0];
          n_q   <= {n_q[126:0], 1'b0};
          q_q   <= {q_q[126:0], ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) begin
            state_q <= D_ROUND;
          end
        end
        D_ROUND: begin
          if (r_q >= (mb_q - r_q)) begin
            q_q <= q_q + 128'd1;
          end
          state_q <= D_PACK;
        end
        D_PACK: begin
          res_q   <= pk.val;
          sat_q   <= pk.sat;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o    = res_q;
  assign sat_o  = sat_q;

endmodule

// ===== hdl/qlsf_multiplier.sv =====
// Fixed-point multiplier from four 32x32 partial products, rounded half away from zero.
module qlsf_multiplier #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o,
  output logic        sat_o
);

  typedef enum logic [1:0] {M_IDLE, M_PART, M_ROUND, M_PACK} mstate_e;

  localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

  mstate_e      state_q;
  logic [1:0]   cnt_q;
  logic [63:0]  ma_q;
  logic [63:0]  mb_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic         done_q;
  logic [63:0]  res_q;
  logic         sat_q;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  part;
  logic [127:0] part_sh;
  logic [127:0] sh;
  qlsf_pkg::fx_res_t pk;

  assign pa   = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb   = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign part = pa * pb;

  always_comb begin
    case (cnt_q)
      2'd0:    part_sh = {64'd0, part};
      2'd3:    part_sh = {part, 64'd0};
      default: part_sh = {32'd0, part, 32'd0};
    endcase
  end

  assign sh = acc_q >> FRAC_BITS;
  assign pk = qlsf_pkg::fx_pack(|sh[127:64], sh[63:0], neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            ma_q    <= qlsf_pkg::mag(a_i);
            mb_q    <= qlsf_pkg::mag(b_i);
            neg_q   <= a_i[63] ^ b_i[63];
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= M_PART;
          end
        end
        M_PART: begin
          acc_q <= acc_q + part_sh;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= M_ROUND;
          end
        end
        M_ROUND: begin
          acc_q   <= acc_q + HALF;
          state_q <= M_PACK;
        end
        M_PACK: begin
          res_q   <= pk.val;
          sat_q   <= pk.sat;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = res_q;
  assign sat_o  = sat_q;

endmodule

// ===== hdl/qlsf_datapath.sv =====
// Datapath: point sums, augmented normal matrix, arithmetic units and result register.
module qlsf_datapath #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qlsf_pkg::cmd_t                  cmd_i,
  output qlsf_pkg::sts_t                  sts_o,
  input  logic                            cfg_we_i,
  input  logic [qlsf_pkg::THR_W-1:0]      cfg_wdata_i,
  input  logic signed [7:0]               x_i,
  input  logic signed [15:0]              y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [qlsf_pkg::OUT_W-1:0]      out_data_o,
  output logic [qlsf_pkg::USER_W-1:0]     out_user_o
);

  localparam int unsigned SW = qlsf_pkg::SUM_W;

  logic [qlsf_pkg::THR_W-1:0] thr_q;
  logic [qlsf_pkg::CNT_W-1:0] cnt_q;
  logic                       ovf_q;
  logic                       st_vld_q;
  logic signed [7:0]          st_x_q;
  logic signed [15:0]         st_y_q;
  logic signed [16:0]         st_x2_q;
  logic signed [23:0]         st_xy_q;
  logic signed [SW-1:0]       sum_q [7];

  logic [63:0] m_q [12];
  logic [63:0] m_d [12];
  logic [63:0] d_q;
  logic [63:0] f_q;
  logic        sat_q;
  logic        sat_d;
  logic        sing_q;

  logic        out_vld_q;
  logic [qlsf_pkg::OUT_W-1:0]  out_data_q;
  logic [qlsf_pkg::USER_W-1:0] out_user_q;

  logic        div_done, mul_done, div_sat, mul_sat;
  logic [63:0] div_q, mul_p;

  logic signed [24:0] x3;
  logic signed [33:0] x4;
  logic signed [31:0] x2y;

  logic [1:0]  piv;
  logic [63:0] pv;
  logic        sing;
  logic [64:0] diff;
  qlsf_pkg::fx_res_t fx [8];

  function automatic qlsf_pkg::fx_res_t to_fixed(input logic signed [SW-1:0] v);
    logic        neg;
    logic [SW-1:0] m;
    logic [63:0] lim;
    neg = v[SW-1];
    m   = neg ? SW'(-v) : v;
    lim = (neg ? qlsf_pkg::NEG_LIMIT : qlsf_pkg::POS_LIMIT) >> FRAC_BITS;
    if (64'(m) > lim) begin
      return qlsf_pkg::fx_pack(1'b1, 64'd0, neg);
    end
    return qlsf_pkg::fx_pack(1'b0, 64'(m) << FRAC_BITS, neg);
  endfunction

  assign x3  = st_x2_q * st_x_q;
  assign x4  = st_x2_q * st_x2_q;
  assign x2y = st_xy_q * st_x_q;

  always_comb begin
    fx[0] = to_fixed(SW'(signed'({1'b0, cnt_q})));
    for (int n = 0; n < 7; n++) begin
      fx[n + 1] = to_fixed(sum_q[n]);
    end
  end

  // pivot search over the rows from i down
  always_comb begin
    piv = cmd_i.i;
    for (int r = 0; r < 3; r++) begin
      if ((2'(r) > cmd_i.i) &&
          (qlsf_pkg::mag(m_q[{2'(r), cmd_i.i}]) > qlsf_pkg::mag(m_q[{piv, cmd_i.i}]))) begin
        piv = 2'(r);
      end
    end
    pv   = m_q[{piv, cmd_i.i}];
    sing = (pv == 64'd0) || (qlsf_pkg::mag(pv) < 64'(thr_q));
  end

  assign diff = {m_q[{cmd_i.j, cmd_i.k}][63], m_q[{cmd_i.j, cmd_i.k}]} - {mul_p[63], mul_p};

  always_comb begin
    for (int n = 0; n < 12; n++) begin
      m_d[n] = m_q[n];
    end
    sat_d = sat_q;
    if (cmd_i.load) begin
      sat_d = 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m_d[r * 4 + c] = fx[r + c].val;
        end
        m_d[r * 4 + 3] = fx[r + 5].val;
      end
      for (int n = 0; n < 8; n++) begin
        sat_d = sat_d | fx[n].sat;
      end
    end else if (cmd_i.pivot) begin
      for (int c = 0; c < 4; c++) begin
        m_d[{cmd_i.i, 2'(c)}] = m_q[{piv, 2'(c)}];
        m_d[{piv, 2'(c)}]     = m_q[{cmd_i.i, 2'(c)}];
      end
    end else if (cmd_i.div_write) begin
      m_d[{cmd_i.i, cmd_i.k}] = div_q;
      sat_d = sat_q | div_sat;
    end else if (cmd_i.sub_write) begin
      if (diff[64] != diff[63]) begin
        m_d[{cmd_i.j, cmd_i.k}] = diff[64] ? qlsf_pkg::NEG_LIMIT : qlsf_pkg::POS_LIMIT;
        sat_d = 1'b1;
      end else begin
        m_d[{cmd_i.j, cmd_i.k}] = diff[63:0];
      end
      sat_d = sat_d | mul_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= qlsf_pkg::THR_W'(1);
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      st_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int n = 0; n < 7; n++) begin
        sum_q[n] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      st_vld_q <= 1'b0;
      if (cmd_i.accept) begin
        if (cnt_q < qlsf_pkg::CNT_W'(MAX_POINTS)) begin
          cnt_q    <= cnt_q + 1'b1;
          st_vld_q <= 1'b1;
          st_x_q   <= x_i;
          st_y_q   <= y_i;
          st_x2_q  <= 17'(x_i) * 17'(x_i);
          st_xy_q  <= 24'(x_i) * 24'(y_i);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (st_vld_q) begin
        sum_q[0] <= sum_q[0] + SW'(st_x_q);
        sum_q[1] <= sum_q[1] + SW'(st_x2_q);
        sum_q[2] <= sum_q[2] + SW'(x3);
        sum_q[3] <= sum_q[3] + SW'(x4);
        sum_q[4] <= sum_q[4] + SW'(st_y_q);
        sum_q[5] <= sum_q[5] + SW'(st_xy_q);
        sum_q[6] <= sum_q[6] + SW'(x2y);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
        cnt_q     <= '0;
        ovf_q     <= 1'b0;
        for (int n = 0; n < 7; n++) begin
          sum_q[n] <= '0;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 12; n++) begin
      m_q[n] <= m_d[n];
    end
    sat_q <= sat_d;
    if (cmd_i.load) begin
      sing_q <= 1'b0;
    end
    if (cmd_i.pivot) begin
      sing_q <= sing;
      d_q    <= pv;
    end
    if (cmd_i.row_start) begin
      f_q <= m_q[{cmd_i.j, cmd_i.i}];
    end
    if (cmd_i.emit) begin
      out_data_q <= {7'd0, cnt_q,
                     sing_q ? 64'd0 : m_q[{2'd2, qlsf_pkg::COL_RHS}],
                     sing_q ? 64'd0 : m_q[{2'd1, qlsf_pkg::COL_RHS}],
                     sing_q ? 64'd0 : m_q[{2'd0, qlsf_pkg::COL_RHS}]};
      out_user_q <= {sat_q | ovf_q, sing_q};
    end
  end

  qlsf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (m_q[{cmd_i.i, cmd_i.k}]),
    .b_i     (d_q),
    .done_o  (div_done),
    .q_o     (div_q),
    .sat_o   (div_sat)
  );

  qlsf_multiplier #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (f_q),
    .b_i     (m_q[{cmd_i.i, cmd_i.k}]),
    .done_o  (mul_done),
    .p_o     (mul_p),
    .sat_o   (mul_sat)
  );

  assign sts_o.singular = sing;
  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_busy = out_vld_q;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// ===== hdl/qlsf_ctrl.sv =====
// Controller: point intake and the Gauss-Jordan sequence.
module qlsf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  qlsf_pkg::sts_t sts_i,
  output qlsf_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_RUN, S_DRAIN, S_LOAD, S_PIVOT, S_DIV_GO, S_DIV_WAIT,
    S_ROW, S_MUL_GO, S_MUL_WAIT, S_SUB, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0] nj;

  always_comb begin
    nj = j_q + 2'd1;
    if (nj == i_q) begin
      nj = nj + 2'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.k = k_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_LOAD;
      S_LOAD: begin
        cmd_o.load = 1'b1;
        i_d        = 2'd0;
        state_d    = S_PIVOT;
      end
      S_PIVOT: begin
        cmd_o.pivot = 1'b1;
        k_d         = 2'd0;
        state_d     = sts_i.singular ? S_EMIT : S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_write = 1'b1;
          if (k_q == qlsf_pkg::COL_RHS) begin
            j_d     = (i_q == 2'd0) ? 2'd1 : 2'd0;
            state_d = S_ROW;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_ROW: begin
        cmd_o.row_start = 1'b1;
        k_d             = 2'd0;
        state_d         = S_MUL_GO;
      end
      S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.sub_write = 1'b1;
        if (k_q == qlsf_pkg::COL_RHS) begin
          if (nj == qlsf_pkg::ROW_END) begin
            if (i_q == 2'd2) begin
              state_d = S_EMIT;
            end else begin
              i_d     = i_q + 2'd1;
              state_d = S_PIVOT;
            end
          end else begin
            j_d     = nj;
            state_d = S_ROW;
          end
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_MUL_GO;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule

// ===== hdl/quadratic_least_squares_fit_core.sv =====
// Top level of the quadratic least-squares fit core.
//  channel  dir  request                 tdata / tuser
//  s_axis   in   one (x, y) point        x_value, y_value / tlast = last_point
//  m_axis   out  one fit result          coefficients, points_used / flags
//  cfg      in   pivot_threshold write   cfg_wdata_i
// One point is taken per cycle while intake is ready; each point is staged
// in registers before the sums add it. After the last point, solve time is mostly
// set by the bit-serial divider (four divisions per pivot row, three rows).
// Intake stays stalled from the last point until the result is loaded.
// Reset clears the sums and sets pivot_threshold to 1.
module quadratic_least_squares_fit_core #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qlsf_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [qlsf_pkg::IN_W-1:0]     s_axis_tdata,  // x_value, y_value
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // coef_const, coef_linear, coef_square, points_used
  output logic [qlsf_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic [qlsf_pkg::USER_W-1:0]   m_axis_tuser   // singular, saturated
);

  qlsf_pkg::cmd_t cmd;
  qlsf_pkg::sts_t sts;

  qlsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qlsf_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .x_i         (s_axis_tdata[7:0]),
    .y_i         (s_axis_tdata[23:8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("intake not stalled after last point");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[191:0] == 192'd0)
    else $error("singular result carries coefficients");

  a_points_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[200:192] <= 9'(MAX_POINTS))
    else $error("points_used above limit");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the quadratic least-squares fit core: point streams in, fits checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint     c0;
    longint     c1;
    longint     c2;
    bit         sing;
    bit         sat;
    bit [8:0]   pts;
  } fit_t;

  typedef struct {
    int   x;
    int   y;
    bit   last;
    bit   typed;
    fit_t want;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [qlsf_pkg::THR_W-1:0]    cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [qlsf_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [qlsf_pkg::OUT_W-1:0]    m_axis_tdata;
  logic [qlsf_pkg::USER_W-1:0]   m_axis_tuser;

  quadratic_least_squares_fit_core dut (.*);

  fit_t        fits_due[$];
  int          errors = 0;
  int          burst_left = 0;
  int          sent = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  int          calm_cnt = 0;

  logic [24:0] thr = 25'd1;
  int          pt_count = 0;
  longint      psum [4];
  longint      csum [3];
  bit          dropped = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("quadratic_least_squares_fit_core test failed");
    $finish;
  end

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint clamp(bit hi_nz, logic [63:0] m, bit neg, inout bit sat);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (hi_nz || m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? longint'(64'd0 - m) : longint'(m);
  endfunction

  function automatic longint q_mul(longint a, longint b, inout bit sat);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p + (128'd1 << 23);
    return clamp(p[127:88] != 0, p[87:24], (a < 0) != (b < 0), sat);
  endfunction

  function automatic longint q_div(longint a, longint b, inout bit sat);
    logic [127:0] num, den, q, rm;
    num = {64'd0, abs64(a)} << 24;
    den = {64'd0, abs64(b)};
    q = num / den;
    rm = num % den;
    if (rm >= den - rm) q = q + 1;
    return clamp(q[127:64] != 0, q[63:0], (a < 0) != (b < 0), sat);
  endfunction

  function automatic longint q_sub(longint a, longint b, inout bit sat);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (d < -65'sh0_8000_0000_0000_0000) begin
      sat = 1'b1;
      return 64'sh8000_0000_0000_0000;
    end
    return longint'(d[63:0]);
  endfunction

  function automatic longint q_from_int(longint v, inout bit sat);
    logic [63:0] m, lim;
    m = abs64(v);
    lim = (v < 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (m > (lim >> 24)) return clamp(1'b1, 64'd0, v < 0, sat);
    return clamp(1'b0, m << 24, v < 0, sat);
  endfunction

  // Solve the normal equations from the running sums, then clear them.
  function automatic fit_t solve_fit();
    fit_t   f;
    longint s [5];
    longint a [9];
    longint r [3];
    longint t, d, g;
    bit     sat, sing;
    int     piv;
    sat = 1'b0;
    sing = 1'b0;
    s[0] = q_from_int(pt_count, sat);
    for (int i = 0; i < 4; i++) s[i+1] = q_from_int(psum[i], sat);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) a[i*3+j] = s[i+j];
      r[i] = q_from_int(csum[i], sat);
    end
    for (int i = 0; i < 3 && !sing; i++) begin
      piv = i;
      for (int j = i + 1; j < 3; j++)
        if (abs64(a[j*3+i]) > abs64(a[piv*3+i])) piv = j;
      for (int k = 0; k < 3; k++) begin
        t = a[i*3+k];
        a[i*3+k] = a[piv*3+k];
        a[piv*3+k] = t;
      end
      t = r[i];
      r[i] = r[piv];
      r[piv] = t;
      d = a[i*3+i];
      if (d == 0 || abs64(d) < {39'd0, thr}) begin
        sing = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) a[i*3+k] = q_div(a[i*3+k], d, sat);
        r[i] = q_div(r[i], d, sat);
        for (int j = 0; j < 3; j++) begin
          if (j != i) begin
            g = a[j*3+i];
            for (int k = 0; k < 3; k++)
              a[j*3+k] = q_sub(a[j*3+k], q_mul(g, a[i*3+k], sat), sat);
            r[j] = q_sub(r[j], q_mul(g, r[i], sat), sat);
          end
        end
      end
    end
    f.c0 = sing ? 0 : r[0];
    f.c1 = sing ? 0 : r[1];
    f.c2 = sing ? 0 : r[2];
    f.sing = sing;
    f.sat = sat || dropped;
    f.pts = 9'(pt_count);
    pt_count = 0;
    psum = '{0, 0, 0, 0};
    csum = '{0, 0, 0};
    dropped = 1'b0;
    return f;
  endfunction

  function automatic void take_point(int x, int y, bit last, bit typed, fit_t want);
    longint xl, yl;
    fit_t   f;
    xl = x;
    yl = y;
    if (pt_count < 256) begin
      psum[0] += xl;
      psum[1] += xl * xl;
      psum[2] += xl * xl * xl;
      psum[3] += xl * xl * xl * xl;
      csum[0] += yl;
      csum[1] += xl * yl;
      csum[2] += xl * xl * yl;
      pt_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      f = solve_fit();
      fits_due.push_back(typed ? want : f);
    end
  endfunction

  task automatic send_point(int x, int y, bit last, bit typed, fit_t want);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {16'(y), 8'(x)};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_point(x, y, last, typed, want);
    burst_left--;
    sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (fits_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [24:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr = v;
    @(posedge clk_i);
  endtask

  task automatic random_fits(int n_items);
    int   len, x, y, start;
    bit   wide_x, wide_y;
    fit_t none;
    none = '{0, 0, 0, 1'b0, 1'b0, 9'd0};
    start = sent;
    while (sent - start < n_items) begin
      case ($urandom_range(0, 39))
        0:       len = $urandom_range(250, 262);
        1:       len = $urandom_range(1, 2);
        default: len = $urandom_range(3, 12);
      endcase
      wide_x = ($urandom_range(0, 3) == 0);
      wide_y = ($urandom_range(0, 2) == 0);
      for (int p = 0; p < len; p++) begin
        x = wide_x ? int'($signed(8'($urandom))) : int'($urandom_range(0, 16)) - 8;
        y = wide_y ? int'($signed(16'($urandom))) : int'($urandom_range(0, 200)) - 100;
        if ($urandom_range(0, 30) == 0) x = 0;
        send_point(x, y, p == len - 1, 1'b0, none);
      end
    end
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    fit_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (fits_due.size() == 0) begin
        report("result with no fit request pending", 1, 0);
      end else begin
        want = fits_due.pop_front();
        if (m_axis_tdata[63:0] !== 64'(want.c0))
          report("coef_const", m_axis_tdata[63:0], want.c0);
        if (m_axis_tdata[127:64] !== 64'(want.c1))
          report("coef_linear", m_axis_tdata[127:64], want.c1);
        if (m_axis_tdata[191:128] !== 64'(want.c2))
          report("coef_square", m_axis_tdata[191:128], want.c2);
        if (m_axis_tdata[200:192] !== want.pts)
          report("points_used", m_axis_tdata[200:192], want.pts);
        if (m_axis_tuser[0] !== want.sing)
          report("singular", m_axis_tuser[0], want.sing);
        if (m_axis_tuser[1] !== want.sat)
          report("saturated", m_axis_tuser[1], want.sat);
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  always @(posedge clk_i) begin
    if (!hold_done && sent > 400) begin
      hold_cnt <= 4000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    if (calm_cnt == 0) begin
      calm <= ~calm;
      calm_cnt <= $urandom_range(50, 400);
    end else begin
      calm_cnt <= calm_cnt - 1;
    end
    m_axis_tready <= (hold_cnt > 0) ? 1'b0 : (calm || $urandom_range(0, 3) != 0);
  end

  initial begin
    row_t rows [$];
    fit_t none;
    none = '{0, 0, 0, 1'b0, 1'b0, 9'd0};
    rows = '{
      '{0, 5, 1'b1, 1'b1, '{0, 0, 0, 1'b1, 1'b0, 9'd1}},
      '{-1, 1, 1'b0, 1'b0, none}, '{0, 0, 1'b0, 1'b0, none}, '{1, 1, 1'b1, 1'b0, none},
      '{-128, -32768, 1'b0, 1'b0, none}, '{127, 32767, 1'b0, 1'b0, none},
      '{0, 0, 1'b1, 1'b0, none},
      '{127, 32767, 1'b0, 1'b0, none}, '{127, 32767, 1'b0, 1'b0, none},
      '{127, -32768, 1'b1, 1'b0, none},
      '{-128, 32767, 1'b1, 1'b0, none},
      '{1, 3, 1'b0, 1'b0, none}, '{2, -7, 1'b0, 1'b0, none}, '{3, 11, 1'b0, 1'b0, none},
      '{4, -20, 1'b0, 1'b0, none}, '{5, 40, 1'b1, 1'b0, none},
      '{-128, -32768, 1'b0, 1'b0, none}, '{-64, 1000, 1'b0, 1'b0, none},
      '{64, -1000, 1'b0, 1'b0, none}, '{127, 32767, 1'b1, 1'b0, none}
    };
    psum = '{0, 0, 0, 0};
    csum = '{0, 0, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].want);
    random_fits(170);
    set_threshold(25'd0);
    random_fits(170);
    set_threshold(25'd16777216);
    random_fits(170);
    set_threshold(25'($urandom_range(2, 16777215)));
    random_fits(170);
    set_threshold(25'd1);
    random_fits(170);
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("quadratic_least_squares_fit_core test passed");
    end else begin
      $display("quadratic_least_squares_fit_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qlsf_pkg.sv
hdl/qlsf_divider.sv
hdl/qlsf_multiplier.sv
hdl/qlsf_datapath.sv
hdl/qlsf_ctrl.sv
hdl/quadratic_least_squares_fit_core.sv
bench/testbench.sv
